// ===== rtl/cfcq_pkg.sv =====
// ----------------------------------------------------------------------------
// cfcq_pkg
// Shared types, sizes and the crc byte update for the command frame checker
// ----------------------------------------------------------------------------
`default_nettype none

package cfcq_pkg;

   // frame and ring sizes
   localparam int CMD_BYTES  = 12;
   localparam int RING_DEPTH = 4;
   localparam int RING_WORDS = RING_DEPTH * CMD_BYTES;

   localparam int ADDR_W = $clog2(RING_WORDS);
   localparam int POS_W  = $clog2(CMD_BYTES + 1);
   localparam int CNT_W  = $clog2(RING_DEPTH);

   // byte positions inside a frame
   localparam logic [POS_W-1:0] POS_ZERO  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_FULL  = POS_W'(CMD_BYTES);
   localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(CMD_BYTES - 2);
   localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(CMD_BYTES - 1);

   // ring addressing
   localparam logic [ADDR_W-1:0] SLOT_STRIDE = ADDR_W'(CMD_BYTES);
   localparam logic [ADDR_W-1:0] LAST_BASE   = ADDR_W'((RING_DEPTH - 1) * CMD_BYTES);
   localparam logic [CNT_W-1:0]  CNT_MAX     = CNT_W'(RING_DEPTH - 1);

   // crc-16/modbus
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // request codes
   localparam logic CMD_FRAME_BYTE = 1'b0;
   localparam logic CMD_POP        = 1'b1;

   typedef enum logic [1:0] {
      KIND_VERDICT = 2'd0,
      KIND_BYTE    = 2'd1,
      KIND_EMPTY   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      V_QUEUED     = 3'd0,
      V_BAD_HEADER = 3'd1,
      V_BAD_CRC    = 3'd2,
      V_FULL       = 3'd3,
      V_SHORT      = 3'd4
   } verdict_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_POP  = 1'b1
   } state_type;

   // ring write port
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } ring_wr_type;

   // one byte of the reflected crc update
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cfcq_ring.sv =====
// ----------------------------------------------------------------------------
// cfcq_ring
// Command ring storage: one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module cfcq_ring (
   input  wire logic                        clock,
   input  wire cfcq_pkg::ring_wr_type       wr,
   input  wire logic                        rd_en,
   input  wire logic [cfcq_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                       rd_data
);

   logic [7:0] mem [cfcq_pkg::RING_WORDS];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/command_frame_checker_queue_top.sv =====
// ----------------------------------------------------------------------------
// command_frame_checker_queue_top
// Checks received command frames and queues good ones for later pops
// ----------------------------------------------------------------------------
// Usage: the req channel carries frame bytes (req_cmd low, req_frame_end on
// the last byte) and pop requests (req_cmd high). Frame bytes are written
// straight into the free ring slot; the crc runs one byte per cycle while
// req is not stalled. At frame end one verdict result comes out on rsp the
// cycle after the transfer. A pop gives one empty-mark result, or CMD_BYTES
// command-byte results streamed from the ring memory, the first through the
// ring read register and the output register, then one per cycle while rsp
// is not stalled; the block takes no request until the last byte is in the
// output register. A result waiting under rsp_stall stays in the output
// register; while it waits the req channel is stalled and the ring read
// stream freezes. csr_header_byte sets the required first frame byte; csr_ready
// is always high. Reset empties the ring, sets the crc to CRC_INIT, clears the
// byte count and sets the header register to zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_checker_queue_top (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_cmd,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_frame_end,
   // result channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_kind,
   output logic [2:0]      rsp_verdict,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_last,
   output logic [1:0]      rsp_queued_count,
   // header register write
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_header_byte
);

   localparam int AW = cfcq_pkg::ADDR_W;
   localparam int PW = cfcq_pkg::POS_W;
   localparam int CW = cfcq_pkg::CNT_W;

   cfcq_pkg::state_type state_ff, state_in;

   logic [7:0]    header_ff;
   logic [15:0]   crc_ff, crc_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    b0_ff, lo_ff, hi_ff;
   logic [AW-1:0] wr_base_ff, wr_base_in;
   logic [AW-1:0] rd_base_ff, rd_base_in;
   logic [CW-1:0] count_ff, count_in;

   // pop stream
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   logic [PW-1:0] issue_idx_ff, issue_idx_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          rd_last_ff, rd_last_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   cfcq_pkg::kind_type       rsp_kind_ff, rsp_kind_in;
   cfcq_pkg::verdict_type    rsp_verdict_ff, rsp_verdict_in;
   logic [7:0]               rsp_out_byte_ff, rsp_out_byte_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [1:0]               rsp_queued_ff, rsp_queued_in;
   logic                     rsp_load;

   cfcq_pkg::ring_wr_type ring_wr;
   logic                  rd_en;
   logic [7:0]            rd_data;

   logic out_free, req_xfer, issue, move;
   logic byte_in_range;
   logic [7:0]  first_byte, rcv_hi;
   logic [15:0] crc_upd, rcv_crc;
   cfcq_pkg::verdict_type verdict;

   assign csr_ready = 1'b1;

   // handshakes
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != cfcq_pkg::ST_IDLE) || !out_free;
   assign req_xfer  = req_valid && !req_stall;

   // frame checks on the byte being taken
   assign byte_in_range = pos_ff < cfcq_pkg::POS_FULL;
   assign crc_upd    = cfcq_pkg::crc_byte(crc_ff, req_data_byte);
   assign first_byte = (pos_ff == cfcq_pkg::POS_ZERO) ? req_data_byte : b0_ff;
   assign rcv_hi     = (pos_ff == cfcq_pkg::POS_CRC_HI) ? req_data_byte : hi_ff;
   assign rcv_crc    = {rcv_hi, lo_ff};

   always_comb begin
      crc_in = crc_ff;
      pos_in = pos_ff;
      if (byte_in_range) begin
         pos_in = pos_ff + PW'(1);
         if (pos_ff < cfcq_pkg::POS_CRC_LO) begin
            crc_in = crc_upd;
         end
      end
   end

   always_comb begin
      priority if (first_byte != header_ff) begin
         verdict = cfcq_pkg::V_BAD_HEADER;
      end else if (pos_in < cfcq_pkg::POS_FULL) begin
         verdict = cfcq_pkg::V_SHORT;
      end else if (rcv_crc != crc_in) begin
         verdict = cfcq_pkg::V_BAD_CRC;
      end else if (count_ff == cfcq_pkg::CNT_MAX) begin
         verdict = cfcq_pkg::V_FULL;
      end else begin
         verdict = cfcq_pkg::V_QUEUED;
      end
   end

   // ring write of incoming frame bytes into the free slot
   always_comb begin
      ring_wr.en   = req_xfer && (req_cmd == cfcq_pkg::CMD_FRAME_BYTE) && byte_in_range;
      ring_wr.addr = wr_base_ff + AW'(pos_ff);
      ring_wr.data = req_data_byte;
   end

   // pop stream control
   assign issue = (state_ff == cfcq_pkg::ST_POP) && (issue_idx_ff != cfcq_pkg::POS_FULL)
                  && (!rd_vld_ff || out_free);
   assign move  = rd_vld_ff && out_free;
   assign rd_en = issue;

   cfcq_ring u_ring (
      .clock   (clock),
      .wr      (ring_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // next state and result selection
   always_comb begin
      state_in        = state_ff;
      wr_base_in      = wr_base_ff;
      rd_base_in      = rd_base_ff;
      count_in        = count_ff;
      rd_addr_in      = rd_addr_ff;
      issue_idx_in    = issue_idx_ff;
      rd_vld_in       = rd_vld_ff;
      rd_last_in      = rd_last_ff;
      rsp_load        = 1'b0;
      rsp_kind_in     = cfcq_pkg::KIND_VERDICT;
      rsp_verdict_in  = cfcq_pkg::V_QUEUED;
      rsp_out_byte_in = 8'h00;
      rsp_last_in     = 1'b1;

      unique case (state_ff)
         cfcq_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_cmd == cfcq_pkg::CMD_POP) begin
                  rsp_load = 1'b1;
                  if (count_ff == CW'(0)) begin
                     rsp_kind_in = cfcq_pkg::KIND_EMPTY;
                  end else begin
                     state_in     = cfcq_pkg::ST_POP;
                     rsp_load     = 1'b0;
                     count_in     = count_ff - CW'(1);
                     rd_addr_in   = rd_base_ff;
                     issue_idx_in = cfcq_pkg::POS_ZERO;
                     rd_base_in   = (rd_base_ff == cfcq_pkg::LAST_BASE) ? AW'(0)
                                    : rd_base_ff + cfcq_pkg::SLOT_STRIDE;
                  end
               end else if (req_frame_end) begin
                  rsp_load       = 1'b1;
                  rsp_verdict_in = verdict;
                  if (verdict == cfcq_pkg::V_QUEUED) begin
                     count_in   = count_ff + CW'(1);
                     wr_base_in = (wr_base_ff == cfcq_pkg::LAST_BASE) ? AW'(0)
                                  : wr_base_ff + cfcq_pkg::SLOT_STRIDE;
                  end
               end
            end
         end
         cfcq_pkg::ST_POP: begin
            if (issue) begin
               rd_addr_in   = rd_addr_ff + AW'(1);
               issue_idx_in = issue_idx_ff + PW'(1);
               rd_vld_in    = 1'b1;
               rd_last_in   = issue_idx_ff == cfcq_pkg::POS_CRC_HI;
            end else if (move) begin
               rd_vld_in = 1'b0;
            end
            if (move) begin
               rsp_load        = 1'b1;
               rsp_kind_in     = cfcq_pkg::KIND_BYTE;
               rsp_out_byte_in = rd_data;
               rsp_last_in     = rd_last_ff;
               if (rd_last_ff) begin
                  state_in = cfcq_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = cfcq_pkg::ST_IDLE;
         end
      endcase

      rsp_queued_in = 2'(count_in);
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfcq_pkg::ST_IDLE;
         header_ff    <= 8'h00;
         crc_ff       <= cfcq_pkg::CRC_INIT;
         pos_ff       <= cfcq_pkg::POS_ZERO;
         wr_base_ff   <= AW'(0);
         rd_base_ff   <= AW'(0);
         count_ff     <= CW'(0);
         rd_vld_ff    <= 1'b0;
         issue_idx_ff <= cfcq_pkg::POS_ZERO;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_base_ff   <= wr_base_in;
         rd_base_ff   <= rd_base_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         issue_idx_ff <= issue_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            header_ff <= csr_header_byte;
         end
         if (req_xfer && (req_cmd == cfcq_pkg::CMD_FRAME_BYTE)) begin
            if (req_frame_end) begin
               crc_ff <= cfcq_pkg::CRC_INIT;
               pos_ff <= cfcq_pkg::POS_ZERO;
            end else begin
               crc_ff <= crc_in;
               pos_ff <= pos_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr_in;
      rd_last_ff <= rd_last_in;
      if (req_xfer && (req_cmd == cfcq_pkg::CMD_FRAME_BYTE)) begin
         if (pos_ff == cfcq_pkg::POS_ZERO) begin
            b0_ff <= req_data_byte;
         end
         if (pos_ff == cfcq_pkg::POS_CRC_LO) begin
            lo_ff <= req_data_byte;
         end
         if (pos_ff == cfcq_pkg::POS_CRC_HI) begin
            hi_ff <= req_data_byte;
         end
      end
      if (rsp_load) begin
         rsp_kind_ff     <= rsp_kind_in;
         rsp_verdict_ff  <= rsp_verdict_in;
         rsp_out_byte_ff <= rsp_out_byte_in;
         rsp_last_ff     <= rsp_last_in;
         rsp_queued_ff   <= rsp_queued_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_verdict      = rsp_verdict_ff;
   assign rsp_out_byte     = rsp_out_byte_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_queued_count = rsp_queued_ff;

   // read stage only holds data while a pop is streaming
   a_rd_only_in_pop: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> state_ff == cfcq_pkg::ST_POP)
      else $error("ring read data valid outside a pop");

   // ring never holds more than depth minus one commands
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cfcq_pkg::CNT_MAX)
      else $error("queued command count out of range");

   // the last streamed byte ends the pop
   a_pop_ends: assert property (@(posedge clock) disable iff (reset)
      (move && rd_last_ff) |=> state_ff == cfcq_pkg::ST_IDLE)
      else $error("pop did not end after its last byte");

   // a queued verdict adds one command
   a_queue_grows: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_cmd == cfcq_pkg::CMD_FRAME_BYTE && req_frame_end
       && verdict == cfcq_pkg::V_QUEUED) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queued frame did not raise the command count");

   // a pop flags its last byte in the ring read stage only once every byte was issued
   a_issue_complete: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cfcq_pkg::ST_POP && rd_vld_ff && rd_last_ff)
      |-> issue_idx_ff == cfcq_pkg::POS_FULL)
      else $error("last byte flagged before all bytes were read");

endmodule

`default_nettype wire
